// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mkh_pkg.sv =====
// ----------------------------------------------------------------------------
// mkh_pkg
// Constants, types and the shared multiply for the key hash block.
// ----------------------------------------------------------------------------
package mkh_pkg;

    localparam int WORD_W = 32;
    localparam int NB_W   = 3;

    localparam logic [WORD_W-1:0] MIX_M      = 32'h5bd1e995;
    localparam int                MIX_R      = 24;
    localparam int                FIN_A      = 13;
    localparam int                FIN_B      = 15;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd5381;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [1:0] t_op_kind;
    localparam t_op_kind OP_NONE = 2'd0;  // no key bytes in this beat
    localparam t_op_kind OP_WORD = 2'd1;  // full four-byte word, value is mixed k
    localparam t_op_kind OP_TAIL = 2'd2;  // one to three bytes, value is masked word

    typedef struct packed {
        t_op_kind          kind;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] key_length;
        logic              first;
        logic              last;
    } t_op;

    function automatic logic [WORD_W-1:0] mulm(input logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] p;
        p = a * MIX_M;
        return p;
    endfunction

endpackage

// ===== rtl/core/mkh_if.sv =====
// ----------------------------------------------------------------------------
// mkh_if
// Valid/ready channels: key words in, hash out, seed writes.
// ----------------------------------------------------------------------------
interface mkh_key_if;
    import mkh_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic [NB_W-1:0]   valid_bytes;
    logic [WORD_W-1:0] key_length;
    logic              first_of_key;
    logic              last_of_key;

    modport source (output valid, data_word, valid_bytes, key_length,
                    first_of_key, last_of_key, input ready);
    modport sink   (input valid, data_word, valid_bytes, key_length,
                    first_of_key, last_of_key, output ready);
endinterface

interface mkh_hash_if;
    import mkh_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

interface mkh_cfg_if;
    import mkh_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] seed_value;

    modport source (output valid, seed_value, input ready);
    modport sink   (input valid, seed_value, output ready);
endinterface

// ===== rtl/core/mkh_front.sv =====
// ----------------------------------------------------------------------------
// mkh_front
// Accepts key beats, classifies them and pre-mixes full words (k*m, xorshift,
// k*m) in a two-stage elastic pipeline.
// ----------------------------------------------------------------------------
module mkh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mkh_key_if.sink       i_key,
    output mkh_pkg::t_op  o_op,
    output logic          o_op_valid,
    input  logic          i_op_ready
);
    import mkh_pkg::*;

    logic [NB_W-1:0]   n_nb;
    t_op_kind          n_kind;
    logic [WORD_W-1:0] n_mask;
    logic [WORD_W-1:0] w_k2;
    logic [WORD_W-1:0] n_value;
    logic              w_push;
    logic              w_en1;
    logic              w_en2;

    logic              r_s1_v;
    t_op_kind          r_s1_kind;
    logic [WORD_W-1:0] r_s1_prod;
    logic [WORD_W-1:0] r_s1_tail;
    logic [WORD_W-1:0] r_s1_klen;
    logic              r_s1_first;
    logic              r_s1_last;

    logic              r_s2_v;
    t_op               r_s2_op;

    always_comb begin
        n_nb = (i_key.valid_bytes > NB_W'(4)) ? NB_W'(4) : i_key.valid_bytes;
        case (n_nb)
            3'd0: begin
                n_kind = OP_NONE;
                n_mask = '0;
            end
            3'd1: begin
                n_kind = OP_TAIL;
                n_mask = 32'h0000_00ff;
            end
            3'd2: begin
                n_kind = OP_TAIL;
                n_mask = 32'h0000_ffff;
            end
            3'd3: begin
                n_kind = OP_TAIL;
                n_mask = 32'h00ff_ffff;
            end
            default: begin
                n_kind = OP_WORD;
                n_mask = '1;
            end
        endcase
    end

    assign w_push      = r_s2_v && i_op_ready;
    assign w_en2       = !r_s2_v || w_push;
    assign w_en1       = !r_s1_v || w_en2;
    assign i_key.ready = w_en1;

    assign w_k2    = r_s1_prod ^ (r_s1_prod >> MIX_R);
    assign n_value = (r_s1_kind == OP_WORD) ? mulm(w_k2) : r_s1_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_v <= i_key.valid;
            end
            if (w_en2) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_key.valid) begin
            r_s1_kind  <= n_kind;
            r_s1_prod  <= mulm(i_key.data_word);
            r_s1_tail  <= i_key.data_word & n_mask;
            r_s1_klen  <= i_key.key_length;
            r_s1_first <= i_key.first_of_key;
            r_s1_last  <= i_key.last_of_key;
        end
        if (w_en2 && r_s1_v) begin
            r_s2_op.kind       <= r_s1_kind;
            r_s2_op.value      <= n_value;
            r_s2_op.key_length <= r_s1_klen;
            r_s2_op.first      <= r_s1_first;
            r_s2_op.last       <= r_s1_last;
        end
    end

    assign o_op       = r_s2_op;
    assign o_op_valid = r_s2_v;

endmodule

// ===== rtl/core/mkh_queue.sv =====
// ----------------------------------------------------------------------------
// mkh_queue
// Small FIFO of classified beats between the front and the accumulator.
// ----------------------------------------------------------------------------
module mkh_queue #(
    parameter int DEPTH = mkh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  mkh_pkg::t_op  i_wr_op,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output mkh_pkg::t_op  o_rd_op
);
    import mkh_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;
    assign o_rd_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_op;
        end
    end

endmodule

// ===== rtl/core/mkh_back.sv =====
// ----------------------------------------------------------------------------
// mkh_back
// Holds the seed and the running hash, folds one beat per cycle (a last beat
// waits for room) and finalizes key hashes through a two-stage pipe to output.
// ----------------------------------------------------------------------------
module mkh_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mkh_cfg_if.sink      i_cfg,
    input  mkh_pkg::t_op  i_op,
    input  logic          i_op_valid,
    output logic          o_op_ready,
    mkh_hash_if.source    o_hash
);
    import mkh_pkg::*;

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_acc;
    logic              r_f1_v;
    logic [WORD_W-1:0] r_f1_h;
    logic              r_f2_v;
    logic [WORD_W-1:0] r_f2_p;
    logic              r_o_v;
    logic [WORD_W-1:0] r_o_hash;

    logic [WORD_W-1:0] w_h0;
    logic [WORD_W-1:0] w_mul_in;
    logic [WORD_W-1:0] w_mul;
    logic [WORD_W-1:0] n_acc;
    logic              w_pop;
    logic              w_en_o;
    logic              w_en2;
    logic              w_en1;

    assign i_cfg.ready = 1'b1;

    assign w_en_o     = !r_o_v || o_hash.ready;
    assign w_en2      = !r_f2_v || w_en_o;
    assign w_en1      = !r_f1_v || w_en2;
    // only a last beat needs room in the finalize pipe
    assign o_op_ready = !i_op.last || w_en1;
    assign w_pop      = i_op_valid && o_op_ready;

    // one multiplier: h*m for a full word, (h^tail)*m for a tail
    always_comb begin
        w_h0     = i_op.first ? (r_seed ^ i_op.key_length) : r_acc;
        w_mul_in = (i_op.kind == OP_TAIL) ? (w_h0 ^ i_op.value) : w_h0;
        w_mul    = mulm(w_mul_in);
        case (i_op.kind)
            OP_WORD: n_acc = w_mul ^ i_op.value;
            OP_TAIL: n_acc = w_mul;
            default: n_acc = w_h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
            r_acc  <= '0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_seed <= i_cfg.seed_value;
            end
            if (w_pop) begin
                r_acc <= n_acc;
            end
            if (w_en1) begin
                r_f1_v <= w_pop && i_op.last;
            end
            if (w_en2) begin
                r_f2_v <= r_f1_v;
            end
            if (w_en_o) begin
                r_o_v <= r_f2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && w_pop) begin
            r_f1_h <= n_acc;
        end
        if (w_en2 && r_f1_v) begin
            r_f2_p <= mulm(r_f1_h ^ (r_f1_h >> FIN_A));
        end
        if (w_en_o && r_f2_v) begin
            r_o_hash <= r_f2_p ^ (r_f2_p >> FIN_B);
        end
    end

    assign o_hash.valid      = r_o_v;
    assign o_hash.hash_value = r_o_hash;

endmodule

// ===== rtl/core/murmur2_key_hash.sv =====
// ----------------------------------------------------------------------------
// murmur2_key_hash
// Streaming 32-bit MurmurHash2 of byte keys sent as little-endian words.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                         beat when
//  i_key     in   data_word, valid_bytes, key_length, first/last  valid && ready
//  o_hash    out  hash_value                                      valid && ready
//  i_cfg     in   seed_value                                      valid && ready
//
//  While o_hash is not stalled, one key beat per cycle is sustained and the
//  accumulator folds one beat per cycle. A last beat, queue idle, passes two
//  front stages, queue write, fold and two finalize stages to o_hash.valid.
//  Reset: seed 5381, running hash 0, all pipes and the queue empty.
//  i_cfg.ready is always high. A stalled output backs up the finalize pipe;
//  beats ahead of the next last beat still fold, then the queue and
//  i_key.ready stall behind it.
// ----------------------------------------------------------------------------
module murmur2_key_hash #(
    parameter int QUEUE_DEPTH = mkh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mkh_cfg_if.sink     i_cfg,
    mkh_key_if.sink     i_key,
    mkh_hash_if.source  o_hash
);
    import mkh_pkg::*;

    t_op  w_fr_op;
    logic w_fr_valid;
    logic w_fr_ready;
    t_op  w_bk_op;
    logic w_bk_valid;
    logic w_bk_ready;

    mkh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (i_key),
        .o_op       (w_fr_op),
        .o_op_valid (w_fr_valid),
        .i_op_ready (w_fr_ready)
    );

    mkh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fr_valid),
        .o_wr_ready (w_fr_ready),
        .i_wr_op    (w_fr_op),
        .o_rd_valid (w_bk_valid),
        .i_rd_ready (w_bk_ready),
        .o_rd_op    (w_bk_op)
    );

    mkh_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_op       (w_bk_op),
        .i_op_valid (w_bk_valid),
        .o_op_ready (w_bk_ready),
        .o_hash     (o_hash)
    );

endmodule

// ===== rtl/core/mkh_chk.sv =====
// ----------------------------------------------------------------------------
// mkh_chk
// Port-level checks on the key hash block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mkh_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_hash_value,
    input logic        i_cfg_ready
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_hash_value))
    `ASSERT_CLK(a_cfg_ready, i_clk, i_rst_n, i_cfg_ready)
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind murmur2_key_hash mkh_chk u_mkh_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_hash.valid),
    .i_out_ready  (o_hash.ready),
    .i_hash_value (o_hash.hash_value),
    .i_cfg_ready  (i_cfg.ready)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams byte keys as little-endian words into murmur2_key_hash. Every
// accepted beat is folded into a local copy of the running hash, and every
// returned hash is checked in order. The seed is rewritten between phases,
// and both channels stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import mkh_pkg::*;

    localparam logic [31:0] MUR_M      = 32'h5bd1e995;
    localparam int          MUR_R      = 24;
    localparam int          MUR_FA     = 13;
    localparam int          MUR_FB     = 15;
    localparam logic [31:0] SEED_AT_RST = 32'd5381;

    localparam int BEATS_PER_PHASE = 165;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 400000;

    // ------------------------------------------------------------------------
    // Running-hash tracker: folds accepted beats, queues finalized hashes.
    // ------------------------------------------------------------------------
    class key_hash_tracker;
        bit [31:0] seed;
        bit [31:0] running_hash;
        bit [31:0] pending_hashes[$];
        int unsigned errors;

        function new();
            seed         = SEED_AT_RST;
            running_hash = '0;
            errors       = 0;
        endfunction

        function bit [31:0] times_m(bit [31:0] a);
            return a * MUR_M;
        endfunction

        function void set_seed(bit [31:0] v);
            seed = v;
        endfunction

        function void note_key_beat(bit [31:0] word, bit [NB_W-1:0] nbytes,
                                    bit [31:0] klen, bit first, bit last);
            bit [31:0] h;
            bit [31:0] k;
            bit [31:0] mask;
            int unsigned n;
            h = first ? (seed ^ klen) : running_hash;
            n = (nbytes > 4) ? 4 : nbytes;
            if (n == 4) begin
                k = times_m(word);
                k = k ^ (k >> MUR_R);
                k = times_m(k);
                h = times_m(h) ^ k;
            end else if (n != 0) begin
                mask = (32'h1 << (8 * n)) - 32'h1;
                h = times_m(h ^ (word & mask));
            end
            running_hash = h;
            if (last) begin
                // the accumulator keeps the unfinalized value
                h = h ^ (h >> MUR_FA);
                h = times_m(h);
                h = h ^ (h >> MUR_FB);
                pending_hashes.push_back(h);
            end
        endfunction

        function void check_hash(bit [31:0] got);
            bit [31:0] want;
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected hash beat, actual %h", $time, got);
                errors++;
            end else begin
                want = pending_hashes.pop_front();
                if (got !== want) begin
                    $display("%0t: hash_value mismatch, expected %h actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return pending_hashes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mkh_cfg_if  cfg_ch();
    mkh_key_if  key_ch();
    mkh_hash_if hash_ch();

    murmur2_key_hash uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_key   (key_ch),
        .o_hash  (hash_ch)
    );

    key_hash_tracker tracker = new();

    bit hold_request = 1'b0;
    bit no_gaps      = 1'b0;
    int unsigned cycle_count = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: all beats sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                tracker.set_seed(cfg_ch.seed_value);
            if (key_ch.valid && key_ch.ready)
                tracker.note_key_beat(key_ch.data_word, key_ch.valid_bytes,
                                      key_ch.key_length, key_ch.first_of_key,
                                      key_ch.last_of_key);
            if (hash_ch.valid && hash_ch.ready)
                tracker.check_hash(hash_ch.hash_value);
        end
    end

    // ------------------------------------------------------------------------
    // Hash receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int unsigned held;
        int unsigned stall;
        forever begin
            if (hold_request) begin
                hash_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_request = 1'b0;
            end else if (no_gaps) begin
                hash_ch.ready <= 1'b1;
                @(posedge clk);
            end else begin
                hash_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                stall = pick_gap();
                if (stall > 0) begin
                    hash_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Key sender tasks
    // ------------------------------------------------------------------------
    int unsigned beats_sent = 0;

    task automatic send_key(input logic [31:0] word, input logic [NB_W-1:0] nbytes,
                            input logic [31:0] klen, input logic first,
                            input logic last);
        key_ch.valid        <= 1'b1;
        key_ch.data_word    <= word;
        key_ch.valid_bytes  <= nbytes;
        key_ch.key_length   <= klen;
        key_ch.first_of_key <= first;
        key_ch.last_of_key  <= last;
        do @(posedge clk); while (!key_ch.ready);
        beats_sent++;
    endtask

    task automatic key_gap(input int unsigned n);
        if (n > 0) begin
            key_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_gapped(input logic [31:0] word, input logic [NB_W-1:0] nbytes,
                               input logic [31:0] klen, input logic first,
                               input logic last);
        send_key(word, nbytes, klen, first, last);
        key_gap(no_gaps ? 0 : pick_gap());
    endtask

    // well-formed key: full words, then an optional tail, first/last marked
    task automatic send_random_key();
        int unsigned len;
        int unsigned full;
        int unsigned tail;
        int unsigned total;
        int unsigned r;
        int unsigned i;
        logic [31:0] klen;
        logic [NB_W-1:0] nb;
        r = $urandom_range(0, 9);
        if (r < 7)      len = $urandom_range(0, 16);
        else if (r < 9) len = $urandom_range(17, 48);
        else            len = $urandom_range(49, 120);
        klen  = ($urandom_range(0, 7) == 0) ? $urandom : len;
        full  = len / 4;
        tail  = len % 4;
        total = full + ((tail != 0 || len == 0) ? 1 : 0);
        for (i = 0; i < total; i++) begin
            nb = (i < full) ? NB_W'(4) : NB_W'(tail);
            send_gapped($urandom, nb, klen, i == 0, i == total - 1);
        end
    endtask

    task automatic run_keys(input int unsigned beats);
        int unsigned stop_at;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                send_gapped($urandom, NB_W'($urandom_range(0, 7)), $urandom,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                send_random_key();
        end
    endtask

    // wait for every hash, then let in-flight non-last beats settle
    task automatic drain();
        key_gap(1);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.seed_value <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] seeds[5];
        int unsigned p;
        seeds[0] = 32'h0000_0000;
        seeds[1] = 32'hffff_ffff;
        seeds[2] = $urandom;
        seeds[3] = $urandom;
        seeds[4] = $urandom;

        rst_n               <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.seed_value   <= '0;
        key_ch.valid        <= 1'b0;
        key_ch.data_word    <= '0;
        key_ch.valid_bytes  <= '0;
        key_ch.key_length   <= '0;
        key_ch.first_of_key <= 1'b0;
        key_ch.last_of_key  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset seed: no first mark continues from a zero accumulator
        send_gapped(32'h11223344, 3'd4, 32'd5, 1'b0, 1'b0);
        send_gapped(32'h555555aa, 3'd1, 32'd0, 1'b0, 1'b1);
        // empty key
        send_gapped(32'hdeadbeef, 3'd0, 32'd0, 1'b1, 1'b1);
        // single tails with junk above the valid bytes, then single full-word keys
        send_gapped(32'hffffffff, 3'd1, 32'd1, 1'b1, 1'b1);
        send_gapped(32'hffffffff, 3'd2, 32'd2, 1'b1, 1'b1);
        send_gapped(32'h80808080, 3'd3, 32'd3, 1'b1, 1'b1);
        send_gapped(32'h00000000, 3'd4, 32'd4, 1'b1, 1'b1);
        send_gapped(32'hffffffff, 3'd4, 32'hffffffff, 1'b1, 1'b1);
        // byte counts above four saturate
        send_gapped(32'h12345678, 3'd5, 32'd4, 1'b1, 1'b1);
        send_gapped(32'h9abcdef0, 3'd6, 32'd4, 1'b1, 1'b1);
        send_gapped(32'h0f0f0f0f, 3'd7, 32'd0, 1'b1, 1'b1);
        // three-beat key
        send_gapped(32'h61626364, 3'd4, 32'd11, 1'b1, 1'b0);
        send_gapped(32'h65666768, 3'd4, 32'd11, 1'b0, 1'b0);
        send_gapped(32'hff6b6a69, 3'd3, 32'd11, 1'b0, 1'b1);
        // partial word not marked last
        send_gapped(32'hcafe0102, 3'd2, 32'd6, 1'b1, 1'b0);
        send_gapped(32'h04030201, 3'd4, 32'd6, 1'b0, 1'b1);
        // abandoned key, restarted by a new first mark
        send_gapped(32'h87654321, 3'd4, 32'd8, 1'b1, 1'b0);
        send_gapped(32'h13572468, 3'd4, 32'd4, 1'b1, 1'b1);
        // continuation after a last: empty beat finalizes the accumulator
        send_gapped(32'h00000000, 3'd0, 32'd0, 1'b0, 1'b1);
        send_gapped(32'ha5a5a5a5, 3'd4, 32'd0, 1'b0, 1'b0);
        send_gapped(32'h5a5a5a5a, 3'd0, 32'd0, 1'b0, 1'b0);
        send_gapped(32'h000000c3, 3'd1, 32'd0, 1'b0, 1'b1);
        drain();

        for (p = 0; p < 5; p++) begin
            write_seed(seeds[p]);
            if (p == 1) hold_request = 1'b1;
            no_gaps = (p == 3);
            run_keys(BEATS_PER_PHASE);
            no_gaps = 1'b0;
            drain();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
